@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and gated by reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every clock edge outside reset.
`define LCGS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a trigger is followed in the next cycle by a consequence.
`define LCGS_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

@@ design/lcgs_pkg.sv @@
// ----------------------------------------------------------------------------
// Grid search package
// Sizes, codes, command and status types and saturating helpers.
// ----------------------------------------------------------------------------
package lcgs_pkg;

    localparam int DIMS         = 10;
    localparam int CONS         = 10;
    localparam int COEF_STRIDE  = 12;
    localparam int COEF_COUNT   = CONS * COEF_STRIDE;
    localparam int GRID_COUNT   = 3 * DIMS;
    localparam int OFFSET_J     = 10;
    localparam int BASE_J       = 11;
    localparam int COORD_FIELDS = 10;

    localparam int D_W     = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam int J_W     = $clog2(COEF_STRIDE);
    localparam int IDX_W   = 7;
    localparam int VAL_W   = 32;
    localparam int SCALE_W = 16;
    localparam int HIT_W   = 48;
    localparam int ACC_W   = 64;
    localparam int TOL_W   = VAL_W + SCALE_W + 1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd19661;
    localparam logic [HIT_W-1:0]   HIT_MAX     = '1;

    // Reciprocal constants for index / 12 over a 7 bit index and index / 3 for indices below 32.
    localparam int RECIP12       = 43;
    localparam int RECIP12_SHIFT = 9;
    localparam int RECIP3        = 11;
    localparam int RECIP3_SHIFT  = 5;

    typedef enum logic [1:0] {
        REQ_COEF,
        REQ_GRID,
        REQ_START,
        REQ_ADVANCE
    } req_t;

    typedef enum logic [1:0] {
        ST_ACK,
        ST_REJECT,
        ST_ACCEPT,
        ST_FINISHED
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ARMED,
        PH_RUN,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_EMPTY,
        OP_ODO,
        OP_MAC,
        OP_OFF,
        OP_BASE,
        OP_CHECK
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_COEF,
        S_LOAD_GRID,
        S_EMPTY,
        S_EMPTY_WAIT,
        S_START_DONE,
        S_FINISH,
        S_ODO,
        S_ODO_WAIT,
        S_ODO_DECIDE,
        S_MAC,
        S_OFF,
        S_BASE,
        S_CHECK,
        S_CHECK_WAIT,
        S_RESULT
    } state_t;

    typedef struct packed {
        op_t            op;
        logic [D_W-1:0] d;
        logic           latch;
        logic           wr_coef;
        logic           wr_grid;
        logic           set_ack;
        logic           set_fin;
        logic           clr_hit;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic carry;
    } dp_stat_t;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W-1:0] s;
        s = a + b;
        if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1])
            s = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        return s;
    endfunction

    function automatic logic [ACC_W-1:0] sat_sub(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W-1:0] s;
        s = a - b;
        if (a[ACC_W-1] != b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1])
            s = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        return s;
    endfunction

endpackage

@@ design/linear_constraint_grid_search_unit.sv @@
// Sequence: a load, or an advance answered finished without stepping, passes through a load
// or finish state to the result beat. A start runs the start sweep over every dimension.
// An advance steps the odometer (skipped for the first after a start; one that ends the
// search stops after it): one odometer step and one multiply-accumulate level per cycle, then
// offset, tolerance and check. One item is in flight; the next beat is taken in the cycle
// after the result beat leaves. Reset is asynchronous, active low, with no memory clearing.
// ----------------------------------------------------------------------------
// Linear constraint grid search unit
// Walks a grid of Q16.16 points and reports points meeting all tolerance
// constraints, one result beat per request beat.
// ----------------------------------------------------------------------------
module linear_constraint_grid_search_unit
    import lcgs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,  // index[6:0], value[38:7], zero pad
    input  logic [1:0]   s_axis_tuser,  // req_type[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [367:0] m_axis_tdata,  // coord_1 .. coord_10 (32 bits each), hit_count[367:320]
    output logic [1:0]   m_axis_tuser,  // status[1:0]
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data
);

    cmd_t                    cmd;
    dp_stat_t                stat;
    status_t                 status_code;
    logic signed [VAL_W-1:0] coord [DIMS];
    logic [HIT_W-1:0]        hit_count;

    lcgs_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_req    (req_t'(s_axis_tuser)),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    lcgs_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_index    (s_axis_tdata[IDX_W-1:0]),
        .in_value    (s_axis_tdata[IDX_W +: VAL_W]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .status_code (status_code),
        .coord       (coord),
        .hit_count   (hit_count)
    );

    for (genvar f = 0; f < COORD_FIELDS; f++)
    begin : g_coord
        if (f < DIMS)
        begin : g_used
            assign m_axis_tdata[f*VAL_W +: VAL_W] = coord[f];
        end
        else
        begin : g_unused
            assign m_axis_tdata[f*VAL_W +: VAL_W] = '0;
        end
    end

    assign m_axis_tdata[COORD_FIELDS*VAL_W +: HIT_W] = hit_count;
    assign m_axis_tuser = status_code;

endmodule

@@ design/lcgs_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lcgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/lcgs_datapath.sv @@
// ----------------------------------------------------------------------------
// Grid search datapath
// Coefficient and grid memories, odometer, multiply-accumulate lanes and
// tolerance check, driven one command per cycle by the controller.
// ----------------------------------------------------------------------------
module lcgs_datapath
    import lcgs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    output dp_stat_t                stat,
    input  logic [IDX_W-1:0]        in_index,
    input  logic signed [VAL_W-1:0] in_value,
    input  logic                    cfg_wr_en,
    input  logic [SCALE_W-1:0]      cfg_wr_data,
    output status_t                 status_code,
    output logic signed [VAL_W-1:0] coord [DIMS],
    output logic [HIT_W-1:0]        hit_count
);

    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    op_t                     op_s1_reg, op_s1_next;
    logic [D_W-1:0]          d_s1_reg, d_s1_next;
    logic                    mac_v_reg, mac_v_next;
    logic                    mac_first_reg, mac_first_next;
    logic signed [ACC_W-1:0] prod_reg [CONS];
    logic signed [ACC_W-1:0] prod_next [CONS];
    logic signed [ACC_W-1:0] acc_reg [CONS];
    logic signed [ACC_W-1:0] acc_next [CONS];
    logic signed [VAL_W-1:0] off_reg [CONS];
    logic signed [VAL_W-1:0] off_next [CONS];
    logic signed [TOL_W-1:0] tol_reg [CONS];
    logic signed [TOL_W-1:0] tol_next [CONS];
    logic signed [VAL_W-1:0] pos_reg [DIMS];
    logic signed [VAL_W-1:0] pos_next [DIMS];
    logic                    empty_reg, empty_next;
    logic                    carry_reg, carry_next;
    status_t                 status_reg, status_next;
    logic                    show_reg, show_next;
    logic [HIT_W-1:0]        hit_reg, hit_next;
    logic [SCALE_W-1:0]      scale_reg, scale_next;

    logic [12:0]             k_prod;
    logic [3:0]              k_sel;
    logic [IDX_W-1:0]        k_base;
    logic [J_W-1:0]          j_sel;
    logic [9:0]              q_prod;
    logic [4:0]              q_sel;
    logic [1:0]              r_sel;
    logic [J_W-1:0]          coef_rd_addr;
    logic signed [VAL_W-1:0] coef_rd [CONS];
    logic signed [VAL_W-1:0] start_rd, end_rd, step_rd;
    logic                    grid_ok;
    logic signed [VAL_W-1:0] pos_sel;
    logic signed [VAL_W:0]   pos_step;
    logic                    carry_in;
    logic                    all_pass;
    logic [ACC_W-1:0]        off_wide [CONS];
    logic [ACC_W-1:0]        diff [CONS];
    logic signed [ACC_W-1:0] mag [CONS];

    // Index decode for the memories.
    always_comb
    begin
        k_prod = 13'(idx_reg) * 13'(RECIP12);
        k_sel  = k_prod[RECIP12_SHIFT +: 4];
        k_base = IDX_W'(k_sel) * IDX_W'(COEF_STRIDE);
        j_sel  = J_W'(idx_reg - k_base);
        q_prod = 10'(idx_reg) * 10'(RECIP3);
        q_sel  = q_prod[RECIP3_SHIFT +: 5];
        r_sel  = 2'(idx_reg - IDX_W'(q_sel) * IDX_W'(3));
        grid_ok = cmd.wr_grid && (idx_reg < IDX_W'(GRID_COUNT));
        case (cmd.op)
            OP_OFF:  coef_rd_addr = J_W'(OFFSET_J);
            OP_BASE: coef_rd_addr = J_W'(BASE_J);
            default: coef_rd_addr = J_W'(cmd.d);
        endcase
    end

    for (genvar k = 0; k < CONS; k++)
    begin : g_coef
        lcgs_ram #(.WIDTH(VAL_W), .DEPTH(COEF_STRIDE)) u_coef_ram (
            .clk     (clk),
            .wr_en   (cmd.wr_coef && (idx_reg < IDX_W'(COEF_COUNT)) && (k_sel == 4'(k))),
            .wr_addr (j_sel),
            .wr_data (val_reg),
            .rd_addr (coef_rd_addr),
            .rd_data (coef_rd[k])
        );
    end

    lcgs_ram #(.WIDTH(VAL_W), .DEPTH(DIMS)) u_start_ram (
        .clk     (clk),
        .wr_en   (grid_ok && (r_sel == 2'd0)),
        .wr_addr (D_W'(q_sel)),
        .wr_data (val_reg),
        .rd_addr (cmd.d),
        .rd_data (start_rd)
    );

    lcgs_ram #(.WIDTH(VAL_W), .DEPTH(DIMS)) u_end_ram (
        .clk     (clk),
        .wr_en   (grid_ok && (r_sel == 2'd1)),
        .wr_addr (D_W'(q_sel)),
        .wr_data (val_reg),
        .rd_addr (cmd.d),
        .rd_data (end_rd)
    );

    lcgs_ram #(.WIDTH(VAL_W), .DEPTH(DIMS)) u_step_ram (
        .clk     (clk),
        .wr_en   (grid_ok && (r_sel == 2'd2)),
        .wr_addr (D_W'(q_sel)),
        .wr_data (val_reg),
        .rd_addr (cmd.d),
        .rd_data (step_rd)
    );

    always_comb
    begin
        idx_next       = cmd.latch ? in_index : idx_reg;
        val_next       = cmd.latch ? in_value : val_reg;
        op_s1_next     = cmd.op;
        d_s1_next      = cmd.d;
        mac_v_next     = (op_s1_reg == OP_MAC);
        mac_first_next = (d_s1_reg == '0);
        empty_next     = empty_reg;
        carry_next     = carry_reg;
        status_next    = status_reg;
        show_next      = show_reg;
        hit_next       = hit_reg;
        scale_next     = cfg_wr_en ? cfg_wr_data : scale_reg;
        pos_sel        = pos_reg[d_s1_reg];
        pos_step       = {pos_sel[VAL_W-1], pos_sel} + {step_rd[VAL_W-1], step_rd};
        carry_in       = (d_s1_reg == D_W'(DIMS - 1)) || carry_reg;
        all_pass       = 1'b1;
        for (int d = 0; d < DIMS; d++)
        begin
            pos_next[d] = pos_reg[d];
        end
        for (int k = 0; k < CONS; k++)
        begin
            prod_next[k] = coef_rd[k] * pos_sel;
            off_next[k]  = (op_s1_reg == OP_OFF) ? coef_rd[k] : off_reg[k];
            tol_next[k]  = (op_s1_reg == OP_BASE)
                           ? $signed({1'b0, scale_reg}) * coef_rd[k] : tol_reg[k];
            acc_next[k]  = acc_reg[k];
            if (mac_v_reg)
            begin
                acc_next[k] = mac_first_reg ? prod_reg[k] : sat_add(acc_reg[k], prod_reg[k]);
            end
            off_wide[k] = {{(ACC_W - VAL_W - 16){off_reg[k][VAL_W-1]}}, off_reg[k], 16'h0000};
            diff[k]     = sat_sub(acc_reg[k], off_wide[k]);
            if (diff[k][ACC_W-1])
            begin
                mag[k] = (diff[k] == {1'b1, {(ACC_W-1){1'b0}}})
                         ? {1'b0, {(ACC_W-1){1'b1}}} : -$signed(diff[k]);
            end
            else
            begin
                mag[k] = diff[k];
            end
            if (mag[k] > ACC_W'(tol_reg[k]))
            begin
                all_pass = 1'b0;
            end
        end

        case (op_s1_reg)
            OP_EMPTY:
            begin
                pos_next[d_s1_reg] = start_rd;
                empty_next = ((d_s1_reg == '0) ? 1'b0 : empty_reg) || (start_rd >= end_rd);
            end
            OP_ODO:
            begin
                if (carry_in)
                begin
                    if (step_rd > 0 && pos_step < $signed({end_rd[VAL_W-1], end_rd}))
                    begin
                        pos_next[d_s1_reg] = pos_step[VAL_W-1:0];
                        carry_next = 1'b0;
                    end
                    else
                    begin
                        pos_next[d_s1_reg] = start_rd;
                        carry_next = 1'b1;
                    end
                end
                else
                begin
                    carry_next = 1'b0;
                end
            end
            OP_CHECK:
            begin
                show_next   = 1'b1;
                status_next = all_pass ? ST_ACCEPT : ST_REJECT;
                if (all_pass && hit_reg != HIT_MAX)
                begin
                    hit_next = hit_reg + HIT_W'(1);
                end
            end
            default:
            begin
            end
        endcase

        if (cmd.set_ack)
        begin
            status_next = ST_ACK;
            show_next   = 1'b0;
        end
        if (cmd.set_fin)
        begin
            status_next = ST_FINISHED;
            show_next   = 1'b0;
        end
        if (cmd.clr_hit)
        begin
            hit_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_s1_reg  <= OP_NONE;
            mac_v_reg  <= 1'b0;
            empty_reg  <= 1'b0;
            carry_reg  <= 1'b0;
            status_reg <= ST_ACK;
            show_reg   <= 1'b0;
            hit_reg    <= '0;
            scale_reg  <= SCALE_RESET;
            for (int d = 0; d < DIMS; d++)
            begin
                pos_reg[d] <= '0;
            end
        end
        else
        begin
            op_s1_reg  <= op_s1_next;
            mac_v_reg  <= mac_v_next;
            empty_reg  <= empty_next;
            carry_reg  <= carry_next;
            status_reg <= status_next;
            show_reg   <= show_next;
            hit_reg    <= hit_next;
            scale_reg  <= scale_next;
            for (int d = 0; d < DIMS; d++)
            begin
                pos_reg[d] <= pos_next[d];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        val_reg       <= val_next;
        d_s1_reg      <= d_s1_next;
        mac_first_reg <= mac_first_next;
        for (int k = 0; k < CONS; k++)
        begin
            prod_reg[k] <= prod_next[k];
            acc_reg[k]  <= acc_next[k];
            off_reg[k]  <= off_next[k];
            tol_reg[k]  <= tol_next[k];
        end
    end

    always_comb
    begin
        stat.empty  = empty_reg;
        stat.carry  = carry_reg;
        status_code = status_reg;
        hit_count   = hit_reg;
        for (int d = 0; d < DIMS; d++)
        begin
            coord[d] = show_reg ? pos_reg[d] : '0;
        end
    end

endmodule

@@ design/lcgs_controller.sv @@
// ----------------------------------------------------------------------------
// Grid search controller
// Sequences loads, search start, odometer steps and the point check, and
// tracks the search phase.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcgs_controller
    import lcgs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  req_t     in_req,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output cmd_t     cmd,
    input  dp_stat_t stat
);

    state_t         state_reg, state_next;
    phase_t         phase_reg, phase_next;
    logic [D_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_req)
                        REQ_COEF:  state_next = S_LOAD_COEF;
                        REQ_GRID:  state_next = S_LOAD_GRID;
                        REQ_START:
                        begin
                            state_next = S_EMPTY;
                            cnt_next   = '0;
                        end
                        REQ_ADVANCE:
                        begin
                            if (phase_reg == PH_ARMED)
                            begin
                                phase_next = PH_RUN;
                                state_next = S_MAC;
                                cnt_next   = '0;
                            end
                            else if (phase_reg == PH_RUN)
                            begin
                                state_next = S_ODO;
                                cnt_next   = D_W'(DIMS - 1);
                            end
                            else
                            begin
                                state_next = S_FINISH;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_LOAD_COEF:  state_next = S_RESULT;
            S_LOAD_GRID:  state_next = S_RESULT;
            S_EMPTY:
            begin
                if (cnt_reg == D_W'(DIMS - 1))
                    state_next = S_EMPTY_WAIT;
                else
                    cnt_next = cnt_reg + D_W'(1);
            end
            S_EMPTY_WAIT: state_next = S_START_DONE;
            S_START_DONE:
            begin
                phase_next = stat.empty ? PH_DONE : PH_ARMED;
                state_next = S_RESULT;
            end
            S_FINISH:     state_next = S_RESULT;
            S_ODO:
            begin
                if (cnt_reg == '0)
                    state_next = S_ODO_WAIT;
                else
                    cnt_next = cnt_reg - D_W'(1);
            end
            S_ODO_WAIT:   state_next = S_ODO_DECIDE;
            S_ODO_DECIDE:
            begin
                if (stat.carry)
                begin
                    phase_next = PH_DONE;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_MAC;
                    cnt_next   = '0;
                end
            end
            S_MAC:
            begin
                if (cnt_reg == D_W'(DIMS - 1))
                    state_next = S_OFF;
                else
                    cnt_next = cnt_reg + D_W'(1);
            end
            S_OFF:        state_next = S_BASE;
            S_BASE:       state_next = S_CHECK;
            S_CHECK:      state_next = S_CHECK_WAIT;
            S_CHECK_WAIT: state_next = S_RESULT;
            S_RESULT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = (state_reg == S_IDLE);
        out_valid   = (state_reg == S_RESULT);
        cmd.op      = OP_NONE;
        cmd.d       = cnt_reg;
        cmd.latch   = in_ready && in_valid;
        cmd.wr_coef = 1'b0;
        cmd.wr_grid = 1'b0;
        cmd.set_ack = 1'b0;
        cmd.set_fin = 1'b0;
        cmd.clr_hit = 1'b0;
        case (state_reg)
            S_LOAD_COEF:
            begin
                cmd.wr_coef = 1'b1;
                cmd.set_ack = 1'b1;
            end
            S_LOAD_GRID:
            begin
                cmd.wr_grid = 1'b1;
                cmd.set_ack = 1'b1;
            end
            S_EMPTY:      cmd.op = OP_EMPTY;
            S_START_DONE:
            begin
                cmd.set_ack = 1'b1;
                cmd.clr_hit = 1'b1;
            end
            S_FINISH:     cmd.set_fin = 1'b1;
            S_ODO:        cmd.op = OP_ODO;
            S_MAC:        cmd.op = OP_MAC;
            S_OFF:        cmd.op = OP_OFF;
            S_BASE:       cmd.op = OP_BASE;
            S_CHECK:      cmd.op = OP_CHECK;
            default:      cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    `LCGS_ASSERT(a_one_side, !(in_ready && out_valid), "input and output sides both open")
    `LCGS_ASSERT(a_cnt_range, cnt_reg <= D_W'(DIMS - 1), "dimension counter out of range")
    `LCGS_ASSERT_NEXT(a_carry_done, (state_reg == S_ODO_DECIDE) && stat.carry, phase_reg == PH_DONE, "odometer carry did not end search")

endmodule
